// ----- rtl/core/sgcm_pkg.sv -----
// Shared types, constants and functions of the SM4-GCM engine.
package sgcm_pkg;

    typedef enum logic [1:0] {
        REQ_START  = 2'd0,
        REQ_AAD    = 2'd1,
        REQ_TEXT   = 2'd2,
        REQ_FINISH = 2'd3
    } t_req;

    typedef enum logic [4:0] {
        PH_IDLE      = 5'b00001,
        PH_AAD       = 5'b00010,
        PH_AAD_DONE  = 5'b00100,
        PH_TEXT      = 5'b01000,
        PH_TEXT_DONE = 5'b10000
    } t_phase;

    localparam logic [2:0] CFG_KEY_HI = 3'd0;
    localparam logic [2:0] CFG_KEY_LO = 3'd1;
    localparam logic [2:0] CFG_IV_HI  = 3'd2;
    localparam logic [2:0] CFG_IV_LO  = 3'd3;
    localparam logic [2:0] CFG_MODE   = 3'd4;

    localparam logic [31:0] FK0 = 32'ha3b1bac6;
    localparam logic [31:0] FK1 = 32'h56aa3350;
    localparam logic [31:0] FK2 = 32'h677d9197;
    localparam logic [31:0] FK3 = 32'hb27022dc;
    localparam logic [7:0]  GF_POLY = 8'he1;

    // Classified command from the front part to the back part.
    typedef struct packed {
        t_req        req;
        logic        seq_err;
        logic        skip;
        logic [4:0]  nbytes;
        logic [63:0] data_hi;
        logic [63:0] data_lo;
    } t_cmd;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48};
        return t[a];
    endfunction

    function automatic logic [31:0] tau(input logic [31:0] x);
        return {sbox(x[31:24]), sbox(x[23:16]), sbox(x[15:8]), sbox(x[7:0])};
    endfunction

    function automatic logic [31:0] ck_word(input logic [4:0] i);
        logic [7:0] b0;
        b0 = {i, 2'b00} * 8'd7;
        return {b0, b0 + 8'd7, b0 + 8'd14, b0 + 8'd21};
    endfunction

    // Mask that keeps the leading n bytes of a 128-bit block.
    function automatic logic [127:0] byte_mask(input logic [4:0] n);
        logic [127:0] m;
        for (int k = 0; k < 16; k++) begin
            m[127 - 8 * k -: 8] = (5'(k) < n) ? 8'hff : 8'h00;
        end
        return m;
    endfunction

endpackage

// ----- rtl/core/sgcm_if.sv -----
// Valid/ready stream and configuration write interfaces.
interface sgcm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [63:0] data_hi;
    logic [63:0] data_lo;
    logic [4:0]  valid_bytes;
    modport source (output valid, req_type, data_hi, data_lo, valid_bytes, input ready);
    modport sink (input valid, req_type, data_hi, data_lo, valid_bytes, output ready);
endinterface

interface sgcm_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_hi;
    logic [63:0] out_lo;
    logic [4:0]  out_bytes;
    logic        tag_ok;
    logic        status;
    modport source (output valid, out_hi, out_lo, out_bytes, tag_ok, status, input ready);
    modport sink (input valid, out_hi, out_lo, out_bytes, tag_ok, status, output ready);
endinterface

interface sgcm_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/sgcm_front.sv -----
// Front part: accepts items, tracks the message phase and classifies each item.
module sgcm_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sgcm_in_if.sink              in_ch,
    output logic                 o_cmd_valid,
    input  logic                 i_cmd_ready,
    output sgcm_pkg::t_cmd       o_cmd
);
    sgcm_pkg::t_phase r_phase, n_phase;
    sgcm_pkg::t_req   req;
    logic [4:0]       nb;
    logic             err;
    logic             acc;

    assign req = sgcm_pkg::t_req'(in_ch.req_type);
    assign nb = (in_ch.valid_bytes > 5'd16) ? 5'd16 : in_ch.valid_bytes;
    assign in_ch.ready = i_cmd_ready;
    assign o_cmd_valid = in_ch.valid;
    assign acc = in_ch.valid && i_cmd_ready;

    always_comb begin
        err = 1'b0;
        n_phase = r_phase;
        case (req)
            sgcm_pkg::REQ_START: begin
                n_phase = sgcm_pkg::PH_AAD;
            end
            sgcm_pkg::REQ_AAD: begin
                if (r_phase != sgcm_pkg::PH_AAD) begin
                    err = 1'b1;
                end else if (nb != 5'd0 && nb < 5'd16) begin
                    n_phase = sgcm_pkg::PH_AAD_DONE;
                end
            end
            sgcm_pkg::REQ_TEXT: begin
                if (r_phase != sgcm_pkg::PH_AAD && r_phase != sgcm_pkg::PH_AAD_DONE &&
                    r_phase != sgcm_pkg::PH_TEXT) begin
                    err = 1'b1;
                end else if (nb != 5'd0) begin
                    n_phase = (nb < 5'd16) ? sgcm_pkg::PH_TEXT_DONE : sgcm_pkg::PH_TEXT;
                end
            end
            default: begin
                if (r_phase == sgcm_pkg::PH_IDLE) begin
                    err = 1'b1;
                end else begin
                    n_phase = sgcm_pkg::PH_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        o_cmd.req     = req;
        o_cmd.seq_err = err;
        o_cmd.skip    = (req == sgcm_pkg::REQ_AAD || req == sgcm_pkg::REQ_TEXT) && nb == 5'd0;
        o_cmd.nbytes  = nb;
        o_cmd.data_hi = in_ch.data_hi;
        o_cmd.data_lo = in_ch.data_lo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= sgcm_pkg::PH_IDLE;
        end else if (acc) begin
            r_phase <= n_phase;
        end
    end
endmodule

// ----- rtl/core/sgcm_queue.sv -----
// Two-entry queue of classified commands between front and back.
module sgcm_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr_valid,
    output logic           o_wr_ready,
    input  sgcm_pkg::t_cmd i_wr_cmd,
    output logic           o_rd_valid,
    input  logic           i_rd_ready,
    output sgcm_pkg::t_cmd o_rd_cmd
);
    sgcm_pkg::t_cmd r_mem [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           wr, rd;

    assign o_wr_ready = r_cnt != 2'd2;
    assign o_rd_valid = r_cnt != 2'd0;
    assign o_rd_cmd = r_mem[r_rp];
    assign wr = i_wr_valid && o_wr_ready;
    assign rd = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_wr_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) begin
                r_wp <= ~r_wp;
            end
            if (rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end
endmodule

// ----- rtl/core/sgcm_back.sv -----
// Back part: SM4 round unit, key schedule, 4-bit GHASH and result register.
module sgcm_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    output logic           o_cmd_ready,
    input  sgcm_pkg::t_cmd i_cmd,
    input  logic [63:0]    i_key_hi,
    input  logic [63:0]    i_key_lo,
    input  logic [31:0]    i_iv_hi,
    input  logic [63:0]    i_iv_lo,
    input  logic           i_decrypt,
    sgcm_out_if.source     out_ch
);
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_KEYX  = 7'b0000010,
        ST_ENCH  = 7'b0000100,
        ST_ENCJ  = 7'b0001000,
        ST_ENCT  = 7'b0010000,
        ST_HASH  = 7'b0100000,
        ST_OUT   = 7'b1000000
    } t_state;

    t_state         r_state;
    logic [31:0]    r_rk [32];
    logic [31:0]    r_x [4];
    logic [4:0]     r_rnd;
    logic [127:0]   r_h, r_mask, r_acc;
    logic [127:0]   r_gx, r_gz, r_gv;
    logic [4:0]     r_gcnt;
    logic [31:0]    r_ctr;
    logic [60:0]    r_aad_cnt, r_txt_cnt;
    sgcm_pkg::t_cmd r_cmd;
    logic [127:0]   r_text;
    logic           r_ovalid;
    logic [63:0]    r_ohi, r_olo;
    logic [4:0]     r_obytes;
    logic           r_tag_ok, r_status;
    logic [31:0]    rk_sel, rin, tb, lin, nx;
    logic [127:0]   blk, mask, din, gv, gz;
    logic           take;

    assign out_ch.valid     = r_ovalid;
    assign out_ch.out_hi    = r_ohi;
    assign out_ch.out_lo    = r_olo;
    assign out_ch.out_bytes = r_obytes;
    assign out_ch.tag_ok    = r_tag_ok;
    assign out_ch.status    = r_status;

    assign o_cmd_ready = (r_state == ST_IDLE) && !r_ovalid;
    assign take = i_cmd_valid && o_cmd_ready;

    // One SM4 round, shared by key expansion and encryption.
    assign rk_sel = (r_state == ST_KEYX) ? sgcm_pkg::ck_word(r_rnd) : r_rk[r_rnd];
    assign rin = r_x[1] ^ r_x[2] ^ r_x[3] ^ rk_sel;
    assign tb = sgcm_pkg::tau(rin);
    assign lin = (r_state == ST_KEYX) ?
        (tb ^ {tb[18:0], tb[31:19]} ^ {tb[8:0], tb[31:9]}) :
        (tb ^ {tb[29:0], tb[31:30]} ^ {tb[21:0], tb[31:22]} ^
         {tb[13:0], tb[31:14]} ^ {tb[7:0], tb[31:8]});
    assign nx = r_x[0] ^ lin;

    assign mask = sgcm_pkg::byte_mask(r_cmd.nbytes);
    assign din = {r_cmd.data_hi, r_cmd.data_lo} & mask;

    // Four GHASH bit steps per cycle.
    always_comb begin
        gz = r_gz;
        gv = r_gv;
        for (int k = 0; k < 4; k++) begin
            if (r_gx[127 - k]) begin
                gz = gz ^ gv;
            end
            gv = {1'b0, gv[127:1]} ^ (gv[0] ? {sgcm_pkg::GF_POLY, 120'd0} : 128'd0);
        end
    end

    always_comb begin
        if (r_state == ST_ENCH) begin
            blk = {i_iv_hi, i_iv_lo, 32'd1};
        end else begin
            blk = {i_iv_hi, i_iv_lo, r_ctr};
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_KEYX) begin
            r_rk[r_rnd] <= nx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ovalid  <= 1'b0;
            r_rnd     <= 5'd0;
            r_gcnt    <= 5'd0;
            r_h       <= '0;
            r_mask    <= '0;
            r_acc     <= '0;
            r_ctr     <= '0;
            r_aad_cnt <= '0;
            r_txt_cnt <= '0;
        end else begin
            if (r_ovalid && out_ch.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (take) begin
                        r_cmd    <= i_cmd;
                        r_ohi    <= '0;
                        r_olo    <= '0;
                        r_obytes <= '0;
                        r_tag_ok <= 1'b0;
                        r_status <= i_cmd.seq_err;
                        r_rnd    <= 5'd0;
                        if (i_cmd.seq_err || i_cmd.skip) begin
                            r_ovalid <= 1'b1;
                        end else begin
                            case (i_cmd.req)
                                sgcm_pkg::REQ_START: begin
                                    r_x[0] <= i_key_hi[63:32] ^ sgcm_pkg::FK0;
                                    r_x[1] <= i_key_hi[31:0] ^ sgcm_pkg::FK1;
                                    r_x[2] <= i_key_lo[63:32] ^ sgcm_pkg::FK2;
                                    r_x[3] <= i_key_lo[31:0] ^ sgcm_pkg::FK3;
                                    r_state <= ST_KEYX;
                                end
                                sgcm_pkg::REQ_AAD: begin
                                    r_gx   <= r_acc ^ ({i_cmd.data_hi, i_cmd.data_lo} &
                                              sgcm_pkg::byte_mask(i_cmd.nbytes));
                                    r_gz   <= '0;
                                    r_gv   <= r_h;
                                    r_gcnt <= 5'd0;
                                    r_aad_cnt <= r_aad_cnt + 61'(i_cmd.nbytes);
                                    r_state <= ST_HASH;
                                end
                                sgcm_pkg::REQ_TEXT: begin
                                    r_x[0] <= blk[127:96];
                                    r_x[1] <= blk[95:64];
                                    r_x[2] <= blk[63:32];
                                    r_x[3] <= blk[31:0];
                                    r_state <= ST_ENCT;
                                end
                                default: begin
                                    r_gx   <= r_acc ^ {r_aad_cnt, 3'b000, r_txt_cnt, 3'b000};
                                    r_gz   <= '0;
                                    r_gv   <= r_h;
                                    r_gcnt <= 5'd0;
                                    r_state <= ST_HASH;
                                end
                            endcase
                        end
                    end
                end
                ST_KEYX, ST_ENCH, ST_ENCJ, ST_ENCT: begin
                    r_x[0] <= r_x[1];
                    r_x[1] <= r_x[2];
                    r_x[2] <= r_x[3];
                    r_x[3] <= nx;
                    r_rnd  <= r_rnd + 5'd1;
                    if (r_rnd == 5'd31) begin
                        case (r_state)
                            ST_KEYX: begin
                                r_x[0] <= '0;
                                r_x[1] <= '0;
                                r_x[2] <= '0;
                                r_x[3] <= '0;
                                r_state <= ST_ENCH;
                            end
                            ST_ENCH: begin
                                r_h <= {nx, r_x[3], r_x[2], r_x[1]};
                                r_x[0] <= blk[127:96];
                                r_x[1] <= blk[95:64];
                                r_x[2] <= blk[63:32];
                                r_x[3] <= blk[31:0];
                                r_state <= ST_ENCJ;
                            end
                            ST_ENCJ: begin
                                r_mask    <= {nx, r_x[3], r_x[2], r_x[1]};
                                r_ctr     <= 32'd2;
                                r_acc     <= '0;
                                r_aad_cnt <= '0;
                                r_txt_cnt <= '0;
                                r_ovalid  <= 1'b1;
                                r_state   <= ST_IDLE;
                            end
                            default: begin
                                r_text <= (din ^ {nx, r_x[3], r_x[2], r_x[1]}) & mask;
                                r_gx   <= r_acc ^ (i_decrypt ? din :
                                          ((din ^ {nx, r_x[3], r_x[2], r_x[1]}) & mask));
                                r_gz   <= '0;
                                r_gv   <= r_h;
                                r_gcnt <= 5'd0;
                                r_ctr  <= r_ctr + 32'd1;
                                r_txt_cnt <= r_txt_cnt + 61'(r_cmd.nbytes);
                                r_state <= ST_HASH;
                            end
                        endcase
                    end
                end
                ST_HASH: begin
                    r_gz   <= gz;
                    r_gv   <= gv;
                    r_gx   <= {r_gx[123:0], 4'd0};
                    r_gcnt <= r_gcnt + 5'd1;
                    if (r_gcnt == 5'd31) begin
                        r_acc   <= gz;
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (r_cmd.req == sgcm_pkg::REQ_TEXT) begin
                        r_ohi    <= r_text[127:64];
                        r_olo    <= r_text[63:0];
                        r_obytes <= r_cmd.nbytes;
                    end else if (r_cmd.req == sgcm_pkg::REQ_FINISH) begin
                        r_ohi    <= r_acc[127:64] ^ r_mask[127:64];
                        r_olo    <= r_acc[63:0] ^ r_mask[63:0];
                        r_tag_ok <= i_decrypt && ((r_acc ^ r_mask) ==
                                    {r_cmd.data_hi, r_cmd.data_lo});
                    end
                    r_ovalid <= 1'b1;
                    r_state  <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end
endmodule

// ----- rtl/core/sm4_gcm_engine_top.sv -----
// Top level of the SM4-GCM engine: configuration registers, front, queue and back.
// Start runs the key schedule, then enciphers H and J0, one SM4 round each cycle.
// AAD and finish run GHASH at four bits a cycle; text runs 32 SM4 rounds
// then GHASH. Errors and empty blocks go straight to the result register.
// One item is in the back unit at a time; a two-entry queue decouples the front.
// Synchronous active-low reset clears the registers, phase and hash state.
module sm4_gcm_engine_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sgcm_cfg_if.sink   cfg,
    sgcm_in_if.sink    in_ch,
    sgcm_out_if.source out_ch
);
    logic [63:0]    r_key_hi, r_key_lo, r_iv_lo;
    logic [31:0]    r_iv_hi;
    logic           r_mode;
    logic           f_valid, f_ready, q_valid, q_ready;
    sgcm_pkg::t_cmd f_cmd, q_cmd;

    assign cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi <= '0;
            r_key_lo <= '0;
            r_iv_hi  <= '0;
            r_iv_lo  <= '0;
            r_mode   <= 1'b0;
        end else if (cfg.valid) begin
            case (cfg.index)
                sgcm_pkg::CFG_KEY_HI: r_key_hi <= cfg.data;
                sgcm_pkg::CFG_KEY_LO: r_key_lo <= cfg.data;
                sgcm_pkg::CFG_IV_HI:  r_iv_hi  <= cfg.data[31:0];
                sgcm_pkg::CFG_IV_LO:  r_iv_lo  <= cfg.data;
                sgcm_pkg::CFG_MODE:   r_mode   <= cfg.data[0];
                default: ;
            endcase
        end
    end

    sgcm_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(in_ch),
        .o_cmd_valid(f_valid), .i_cmd_ready(f_ready), .o_cmd(f_cmd)
    );

    sgcm_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_wr_valid(f_valid), .o_wr_ready(f_ready), .i_wr_cmd(f_cmd),
        .o_rd_valid(q_valid), .i_rd_ready(q_ready), .o_rd_cmd(q_cmd)
    );

    sgcm_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(q_valid), .o_cmd_ready(q_ready), .i_cmd(q_cmd),
        .i_key_hi(r_key_hi), .i_key_lo(r_key_lo), .i_iv_hi(r_iv_hi),
        .i_iv_lo(r_iv_lo), .i_decrypt(r_mode), .out_ch(out_ch)
    );
endmodule

// ----- tb/tb_sm4_gcm_engine_top.sv -----
// Self-checking testbench of the SM4-GCM engine: directed table, then random message sequences.
module tb_sm4_gcm_engine_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]  req;
        logic [63:0] dhi;
        logic [63:0] dlo;
        logic [4:0]  nb;
        logic        chk;
        logic        st;
    } t_row;

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
        logic [4:0]  nb;
        logic        ok;
        logic        st;
    } t_res;

    logic i_clk;
    logic i_rst_n;
    sgcm_cfg_if cfg ();
    sgcm_in_if in_ch ();
    sgcm_out_if out_ch ();

    sm4_gcm_engine_top u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .cfg    (cfg.sink),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // Predictor state.
    logic [63:0]  m_key_hi, m_key_lo, m_iv_lo;
    logic [31:0]  m_iv_hi;
    logic         m_dec;
    logic [31:0]  m_rk [32];
    logic [127:0] m_h, m_mask, m_acc;
    logic [31:0]  m_ctr;
    logic [60:0]  m_aad_len, m_txt_len;
    sgcm_pkg::t_phase m_ph;

    t_res   result_q[$];
    int     errors = 0;
    int     n_items = 0;
    int     n_results = 0;
    int     n_tags_ok = 0;
    logic   sending = 1'b0;

    function automatic logic [7:0] s_byte(input logic [7:0] a);
        logic [7:0] t [256];
        t = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48};
        return t[a];
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] x);
        return {s_byte(x[31:24]), s_byte(x[23:16]), s_byte(x[15:8]), s_byte(x[7:0])};
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [127:0] keep_bytes(input int n);
        logic [127:0] m;
        for (int k = 0; k < 16; k++) m[127 - 8 * k -: 8] = (k < n) ? 8'hff : 8'h00;
        return m;
    endfunction

    task automatic schedule_keys();
        logic [31:0] k [4];
        logic [31:0] b, c;
        k[0] = m_key_hi[63:32] ^ 32'ha3b1bac6;
        k[1] = m_key_hi[31:0] ^ 32'h56aa3350;
        k[2] = m_key_lo[63:32] ^ 32'h677d9197;
        k[3] = m_key_lo[31:0] ^ 32'hb27022dc;
        for (int i = 0; i < 32; i++) begin
            for (int j = 0; j < 4; j++) c[31 - 8 * j -: 8] = 8'((4 * i + j) * 7);
            b = sub_word(k[(i + 1) % 4] ^ k[(i + 2) % 4] ^ k[(i + 3) % 4] ^ c);
            k[i % 4] = k[i % 4] ^ b ^ rotl(b, 13) ^ rotl(b, 23);
            m_rk[i] = k[i % 4];
        end
    endtask

    function automatic logic [127:0] encipher(input logic [127:0] blk);
        logic [31:0] x [4];
        logic [31:0] b;
        for (int j = 0; j < 4; j++) x[j] = blk[127 - 32 * j -: 32];
        for (int i = 0; i < 32; i++) begin
            b = sub_word(x[(i + 1) % 4] ^ x[(i + 2) % 4] ^ x[(i + 3) % 4] ^ m_rk[i]);
            x[i % 4] ^= b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
        end
        return {x[3], x[2], x[1], x[0]};
    endfunction

    task automatic hash_in(input logic [127:0] blk);
        logic [127:0] x, v, z;
        x = m_acc ^ blk;
        v = m_h;
        z = '0;
        for (int i = 0; i < 128; i++) begin
            if (x[127 - i]) z ^= v;
            v = v[0] ? ((v >> 1) ^ {8'he1, 120'd0}) : (v >> 1);
        end
        m_acc = z;
    endtask

    task automatic predict(input t_row r, output t_res e);
        int n;
        logic [127:0] m, d, ks, o;
        n = (r.nb > 16) ? 16 : int'(r.nb);
        e = '{64'd0, 64'd0, 5'd0, 1'b0, 1'b0};
        case (sgcm_pkg::t_req'(r.req))
            sgcm_pkg::REQ_START: begin
                schedule_keys();
                m_h = encipher('0);
                m_mask = encipher({m_iv_hi, m_iv_lo, 32'd1});
                m_ctr = 32'd2;
                m_acc = '0;
                m_aad_len = '0;
                m_txt_len = '0;
                m_ph = sgcm_pkg::PH_AAD;
            end
            sgcm_pkg::REQ_AAD: begin
                if (m_ph != sgcm_pkg::PH_AAD) begin
                    e.st = 1'b1;
                end else if (n != 0) begin
                    hash_in({r.dhi, r.dlo} & keep_bytes(n));
                    m_aad_len += 61'(n);
                    if (n < 16) m_ph = sgcm_pkg::PH_AAD_DONE;
                end
            end
            sgcm_pkg::REQ_TEXT: begin
                if (!(m_ph inside {sgcm_pkg::PH_AAD, sgcm_pkg::PH_AAD_DONE,
                                   sgcm_pkg::PH_TEXT})) begin
                    e.st = 1'b1;
                end else if (n != 0) begin
                    m = keep_bytes(n);
                    ks = encipher({m_iv_hi, m_iv_lo, m_ctr});
                    m_ctr++;
                    d = {r.dhi, r.dlo} & m;
                    o = (d ^ ks) & m;
                    hash_in(m_dec ? d : o);
                    m_txt_len += 61'(n);
                    m_ph = (n < 16) ? sgcm_pkg::PH_TEXT_DONE : sgcm_pkg::PH_TEXT;
                    {e.hi, e.lo} = o;
                    e.nb = 5'(n);
                end
            end
            default: begin
                if (m_ph == sgcm_pkg::PH_IDLE) begin
                    e.st = 1'b1;
                end else begin
                    hash_in({m_aad_len, 3'b000, m_txt_len, 3'b000});
                    o = m_acc ^ m_mask;
                    {e.hi, e.lo} = o;
                    e.ok = m_dec && (o == {r.dhi, r.dlo});
                    m_ph = sgcm_pkg::PH_IDLE;
                end
            end
        endcase
    endtask

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("** sm4_gcm_engine_top: FAILED **");
        $finish;
    end

    // Result sink with random stall per beat.
    int stall = 0;
    always @(negedge i_clk) begin
        if (stall > 0) begin
            out_ch.ready <= 1'b0;
            stall <= stall - 1;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            n_results++;
            stall <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if (result_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result hi=%h lo=%h", $time, out_ch.out_hi,
                         out_ch.out_lo);
            end else begin
                e = result_q.pop_front();
                if (out_ch.out_hi !== e.hi || out_ch.out_lo !== e.lo ||
                    out_ch.out_bytes !== e.nb || out_ch.tag_ok !== e.ok ||
                    out_ch.status !== e.st) begin
                    errors++;
                    $display("%0t: mismatch expected %h %h nb=%0d ok=%b st=%b", $time,
                             e.hi, e.lo, e.nb, e.ok, e.st);
                    $display("%0t:          actual   %h %h nb=%0d ok=%b st=%b", $time,
                             out_ch.out_hi, out_ch.out_lo, out_ch.out_bytes,
                             out_ch.tag_ok, out_ch.status);
                end
                if (e.ok) n_tags_ok++;
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do @(posedge i_clk); while (!cfg.ready);
        case (idx)
            sgcm_pkg::CFG_KEY_HI: m_key_hi = val;
            sgcm_pkg::CFG_KEY_LO: m_key_lo = val;
            sgcm_pkg::CFG_IV_HI:  m_iv_hi = val[31:0];
            sgcm_pkg::CFG_IV_LO:  m_iv_lo = val;
            default:              m_dec = val[0];
        endcase
        @(negedge i_clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic send(input t_row r, input int gap);
        t_res e;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.req_type    <= r.req;
        in_ch.data_hi     <= r.dhi;
        in_ch.data_lo     <= r.dlo;
        in_ch.valid_bytes <= r.nb;
        do @(posedge i_clk); while (!in_ch.ready);
        predict(r, e);
        if (r.chk && e.st !== r.st) begin
            errors++;
            $display("%0t: model mismatch expected st=%b actual %b", $time, r.st, e.st);
        end
        result_q.push_back(e);
        n_items++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        int guard;
        in_ch.valid <= 1'b0;
        guard = 0;
        while (result_q.size() != 0 && guard < 200000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (120) @(negedge i_clk);
    endtask

    function automatic int pick_gap();
        return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
    endfunction

    task automatic random_message();
        t_row r;
        int na, nt;
        r = '{sgcm_pkg::REQ_START, {$urandom, $urandom}, {$urandom, $urandom}, 5'd0, 1'b0,
              1'b0};
        send(r, pick_gap());
        na = $urandom_range(0, 3);
        nt = $urandom_range(0, 5);
        for (int i = 0; i < na + nt + 1; i++) begin
            r.dhi = {$urandom, $urandom};
            r.dlo = {$urandom, $urandom};
            r.req = (i < na) ? sgcm_pkg::REQ_AAD :
                    (i < na + nt) ? sgcm_pkg::REQ_TEXT : sgcm_pkg::REQ_FINISH;
            r.nb = ($urandom_range(0, 3) != 0) ? 5'd16 : 5'($urandom_range(0, 31));
            if ($urandom_range(0, 12) == 0) r.req = 2'($urandom_range(0, 3));
            send(r, pick_gap());
        end
    endtask

    t_row dir [$];
    initial begin
        i_rst_n = 1'b0;
        cfg.valid = 1'b0; cfg.index = sgcm_pkg::CFG_KEY_HI; cfg.data = '0;
        in_ch.valid = 1'b0; in_ch.req_type = sgcm_pkg::REQ_START; in_ch.data_hi = '0;
        in_ch.data_lo = '0; in_ch.valid_bytes = '0;
        out_ch.ready = 1'b0;
        m_key_hi = '0; m_key_lo = '0; m_iv_hi = '0; m_iv_lo = '0; m_dec = 1'b0;
        foreach (m_rk[i]) m_rk[i] = '0;
        m_h = '0; m_mask = '0; m_acc = '0; m_ctr = '0;
        m_aad_len = '0; m_txt_len = '0; m_ph = sgcm_pkg::PH_IDLE;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Out-of-order items after reset, then a full message with edge cases.
        dir = '{
            '{sgcm_pkg::REQ_AAD,    '1, '1, 5'd16, 1'b1, 1'b1},
            '{sgcm_pkg::REQ_TEXT,   '1, '1, 5'd16, 1'b1, 1'b1},
            '{sgcm_pkg::REQ_FINISH, '0, '0, 5'd0,  1'b1, 1'b1},
            '{sgcm_pkg::REQ_START,  '0, '0, 5'd0,  1'b1, 1'b0},
            '{sgcm_pkg::REQ_AAD,    '0, '0, 5'd0,  1'b1, 1'b0},
            '{sgcm_pkg::REQ_AAD,    '1, '1, 5'd16, 1'b1, 1'b0},
            '{sgcm_pkg::REQ_AAD,    '1, '1, 5'd31, 1'b1, 1'b0},
            '{sgcm_pkg::REQ_AAD,    '1, '1, 5'd7,  1'b1, 1'b0},
            '{sgcm_pkg::REQ_AAD,    '1, '1, 5'd16, 1'b1, 1'b1},
            '{sgcm_pkg::REQ_TEXT,   '0, '0, 5'd16, 1'b0, 1'b0},
            '{sgcm_pkg::REQ_TEXT,   '1, '1, 5'd0,  1'b0, 1'b0},
            '{sgcm_pkg::REQ_TEXT,   '1, '1, 5'd9,  1'b0, 1'b0},
            '{sgcm_pkg::REQ_TEXT,   '1, '1, 5'd16, 1'b1, 1'b1},
            '{sgcm_pkg::REQ_FINISH, '1, '1, 5'd0,  1'b0, 1'b0},
            '{sgcm_pkg::REQ_FINISH, '1, '1, 5'd0,  1'b1, 1'b1},
            '{sgcm_pkg::REQ_START,  '1, '1, 5'd1,  1'b1, 1'b0},
            '{sgcm_pkg::REQ_TEXT,   '1, '0, 5'd1,  1'b0, 1'b0},
            '{sgcm_pkg::REQ_FINISH, '0, '0, 5'd0,  1'b0, 1'b0}
        };
        foreach (dir[i]) send(dir[i], 0);
        drain();

        write_reg(sgcm_pkg::CFG_KEY_HI, '1);
        write_reg(sgcm_pkg::CFG_KEY_LO, '1);
        write_reg(sgcm_pkg::CFG_IV_HI, 64'hffff_ffff);
        write_reg(sgcm_pkg::CFG_IV_LO, '1);
        write_reg(sgcm_pkg::CFG_MODE, 64'd1);

        while (n_items < 1100) begin
            random_message();
            if ($urandom_range(0, 9) == 0) begin
                drain();
                write_reg(sgcm_pkg::CFG_KEY_HI, {$urandom, $urandom});
                write_reg(sgcm_pkg::CFG_KEY_LO, {$urandom, $urandom});
                write_reg(sgcm_pkg::CFG_IV_HI, {32'd0, $urandom});
                write_reg(sgcm_pkg::CFG_IV_LO,
                          ($urandom_range(0, 5) == 0) ? 64'd0 : {$urandom, $urandom});
                write_reg(sgcm_pkg::CFG_MODE, 64'($urandom_range(0, 1)));
            end
        end
        drain();

        $display("Sent %0d items in random messages over both modes; %0d results checked,",
                 n_items, n_results);
        $display("%0d decrypt tags matched.", n_tags_ok);
        if (errors == 0 && result_q.size() == 0) begin
            $display("** sm4_gcm_engine_top: PASSED **");
        end else begin
            $display("** sm4_gcm_engine_top: FAILED **");
        end
        $finish;
    end

endmodule
